>>> hdl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: shared types and constants
// Matrix and pipeline side types, branch codes and saturation limits.
// ----------------------------------------------------------------------------
package rmq_pkg;

    // Width of one quotient of the pair lanes; a larger quotient saturates.
    localparam int QB = 17;

    localparam logic [15:0] SAT_POS = 16'h7FFF;
    localparam logic [15:0] SAT_NEG = 16'h8000;

    typedef logic [1:0] t_branch;

    localparam t_branch BR_TRACE = 2'd0;
    localparam t_branch BR_X     = 2'd1;
    localparam t_branch BR_Y     = 2'd2;
    localparam t_branch BR_Z     = 2'd3;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } t_mat;

    // Pair values that travel beside the square root.
    typedef struct packed {
        t_branch            branch;
        logic signed [16:0] d0;
        logic signed [16:0] d1;
        logic signed [16:0] d2;
    } t_front_side;

    // Control that travels beside the dividers.
    typedef struct packed {
        t_branch     branch;
        logic [15:0] rootq;
        logic [2:0]  neg;
        logic [2:0]  ovf;
    } t_div_side;

endpackage

>>> hdl/rmq_if.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: channel interfaces
// Valid/ready channels for the matrix input and the quaternion result.
// ----------------------------------------------------------------------------
interface rmq_mat_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;

    modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   input ready);
    modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                 output ready);
endinterface

interface rmq_quat_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic [1:0]         branch_taken;

    modport source(output valid, quat_w, quat_x, quat_y, quat_z, branch_taken,
                   input ready);
    modport sink(input valid, quat_w, quat_x, quat_y, quat_z, branch_taken,
                 output ready);
endinterface

>>> hdl/rmq_front.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: front stage
// Picks the branch, forms the clamped radicand and the three pair values.
// ----------------------------------------------------------------------------
module rmq_front #(
    parameter int FRAC_BITS = 14,
    parameter int UW        = 18
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  rmq_pkg::t_mat            i_mat,
    output logic [UW-1:0]            o_rad,
    output rmq_pkg::t_front_side     o_side
);
    import rmq_pkg::*;

    localparam int RW = UW + 1;
    localparam logic signed [RW-1:0] ONE_R = RW'(1) << FRAC_BITS;

    logic signed [17:0]   trace;
    logic signed [17:0]   sum;
    logic signed [RW-1:0] rad_s;
    logic [1:0]           idx;
    t_front_side          side;

    always_comb begin
        trace = 18'(i_mat.m00) + 18'(i_mat.m11) + 18'(i_mat.m22);
        idx   = (i_mat.m11 > i_mat.m00) ? 2'd1 : 2'd0;
        if (i_mat.m22 > ((idx == 2'd1) ? i_mat.m11 : i_mat.m00)) begin
            idx = 2'd2;
        end
        if (trace > 0) begin
            sum         = trace;
            side.branch = BR_TRACE;
            side.d0     = 17'(i_mat.m21) - 17'(i_mat.m12);
            side.d1     = 17'(i_mat.m02) - 17'(i_mat.m20);
            side.d2     = 17'(i_mat.m10) - 17'(i_mat.m01);
        end else if (idx == 2'd0) begin
            sum         = 18'(i_mat.m00) - 18'(i_mat.m11) - 18'(i_mat.m22);
            side.branch = BR_X;
            side.d0     = 17'(i_mat.m21) - 17'(i_mat.m12);
            side.d1     = 17'(i_mat.m10) + 17'(i_mat.m01);
            side.d2     = 17'(i_mat.m20) + 17'(i_mat.m02);
        end else if (idx == 2'd1) begin
            sum         = 18'(i_mat.m11) - 18'(i_mat.m22) - 18'(i_mat.m00);
            side.branch = BR_Y;
            side.d0     = 17'(i_mat.m02) - 17'(i_mat.m20);
            side.d1     = 17'(i_mat.m21) + 17'(i_mat.m12);
            side.d2     = 17'(i_mat.m01) + 17'(i_mat.m10);
        end else begin
            sum         = 18'(i_mat.m22) - 18'(i_mat.m00) - 18'(i_mat.m11);
            side.branch = BR_Z;
            side.d0     = 17'(i_mat.m10) - 17'(i_mat.m01);
            side.d1     = 17'(i_mat.m02) + 17'(i_mat.m20);
            side.d2     = 17'(i_mat.m12) + 17'(i_mat.m21);
        end
        rad_s = RW'(sum) + ONE_R;
        // A radicand at or below zero is clamped to one LSB.
        if (rad_s <= 0) begin
            rad_s = RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rad  <= rad_s[UW-1:0];
            o_side <= side;
        end
    end

endmodule

>>> hdl/rmq_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: square root cell
// One result bit of the integer square root per cell.
// ----------------------------------------------------------------------------
module rmq_sqrt_cell #(
    parameter int RTW = 16,
    parameter int NWE = 32
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [RTW+2:0]   i_rem,
    input  logic [RTW-1:0]   i_root,
    input  logic [NWE-1:0]   i_n,
    output logic [RTW+2:0]   o_rem,
    output logic [RTW-1:0]   o_root,
    output logic [NWE-1:0]   o_n
);
    localparam int REMW = RTW + 3;

    logic [REMW-1:0] rem2;
    logic [REMW-1:0] trial;
    logic            take;

    always_comb begin
        rem2  = {i_rem[REMW-3:0], i_n[NWE-1 -: 2]};
        trial = REMW'({i_root, 2'b01});
        take  = (rem2 >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= take ? (rem2 - trial) : rem2;
            o_root <= {i_root[RTW-2:0], take};
            o_n    <= {i_n[NWE-3:0], 2'b00};
        end
    end

endmodule

>>> hdl/rmq_div_cell.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: divider cell
// One quotient bit of a restoring division per cell.
// ----------------------------------------------------------------------------
module rmq_div_cell #(
    parameter int DW = 17
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [DW-1:0]         i_rem,
    input  logic [DW-1:0]         i_den,
    input  logic [rmq_pkg::QB-1:0] i_low,
    input  logic [rmq_pkg::QB-1:0] i_q,
    output logic [DW-1:0]         o_rem,
    output logic [rmq_pkg::QB-1:0] o_low,
    output logic [rmq_pkg::QB-1:0] o_q
);
    import rmq_pkg::*;

    logic [DW:0] rem2;
    logic [DW:0] diff;
    logic        take;

    always_comb begin
        rem2 = {i_rem, i_low[QB-1]};
        diff = rem2 - {1'b0, i_den};
        take = (rem2 >= {1'b0, i_den});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= take ? diff[DW-1:0] : rem2[DW-1:0];
            o_low <= {i_low[QB-2:0], 1'b0};
            o_q   <= {i_q[QB-2:0], take};
        end
    end

endmodule

>>> hdl/rotation_matrix_to_quaternion_core.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion core
// Fixed-point 3x3 rotation matrix in, unit quaternion and branch code out.
// ----------------------------------------------------------------------------
// One matrix is accepted every clock cycle while the pipeline is not held, and one
// result leaves for each. The path is a front stage, one square root cell per root
// bit (RTW = ceil((max(FRAC_BITS+1,18)+FRAC_BITS)/2) is the number of square root
// cells), a setup stage, seventeen divider cells per pair lane and the output
// register. A two-entry output buffer keeps input transfers going while a
// result waits; the pipeline holds only when both entries are full.
module rotation_matrix_to_quaternion_core #(
    parameter int FRAC_BITS = 14
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rmq_mat_if.sink    i_mat,
    rmq_quat_if.source o_quat
);
    import rmq_pkg::*;

    localparam int UW   = ((FRAC_BITS + 1) > 18) ? (FRAC_BITS + 1) : 18;
    localparam int NW   = UW + FRAC_BITS;
    localparam int NWE  = NW + (NW % 2);
    localparam int RTW  = NWE / 2;
    localparam int DW   = RTW + 1;
    localparam int NNW  = FRAC_BITS + 18;
    localparam int LAST = RTW + 1 + QB;

    logic        en;
    logic [LAST:0] r_v;

    t_mat        mat;
    logic [UW-1:0] front_rad;

    logic [RTW+2:0] w_rem  [0:RTW];
    logic [RTW-1:0] w_root [0:RTW];
    logic [NWE-1:0] w_n    [0:RTW];
    t_front_side    w_fside [0:RTW];
    t_front_side    r_fside [1:RTW];

    logic [DW-1:0]  w_drem [0:2][0:QB];
    logic [QB-1:0]  w_dlow [0:2][0:QB];
    logic [QB-1:0]  w_dq   [0:2][0:QB];
    logic [DW-1:0]  r_p_rem [0:2];
    logic [QB-1:0]  r_p_low [0:2];
    t_div_side      r_dside [0:QB];
    logic [DW-1:0]  r_den   [0:QB];

    logic [RTW-1:0]     p_root;
    logic [RTW:0]       p_half;
    logic signed [16:0] p_d    [0:2];
    logic [16:0]        p_mag  [0:2];
    logic [NNW-1:0]     p_num  [0:2];
    logic [DW-1:0]      p_top  [0:2];
    t_div_side          p_side;

    logic [15:0] res_lane [0:2];
    logic [QB-1:0] lq;
    t_div_side   fin;
    logic [15:0] res_w, res_x, res_y, res_z;

    logic        r_ov, r_skv;
    logic [15:0] r_ow, r_ox, r_oy, r_oz, r_sw, r_sx, r_sy, r_sz;
    t_branch     r_ob, r_sb;
    logic        incoming;

    assign en          = !r_skv;
    assign i_mat.ready = en;
    assign incoming    = en && r_v[LAST];

    assign mat = '{m00: i_mat.m00, m01: i_mat.m01, m02: i_mat.m02,
                   m10: i_mat.m10, m11: i_mat.m11, m12: i_mat.m12,
                   m20: i_mat.m20, m21: i_mat.m21, m22: i_mat.m22};

    rmq_front #(.FRAC_BITS(FRAC_BITS), .UW(UW)) u_front (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mat (mat),
        .o_rad (front_rad),
        .o_side(w_fside[0])
    );

    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_n[0]    = NWE'({front_rad, {FRAC_BITS{1'b0}}});

    for (genvar s = 1; s <= RTW; s++) begin : g_sqrt
        rmq_sqrt_cell #(.RTW(RTW), .NWE(NWE)) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_rem (w_rem[s-1]),
            .i_root(w_root[s-1]),
            .i_n   (w_n[s-1]),
            .o_rem (w_rem[s]),
            .o_root(w_root[s]),
            .o_n   (w_n[s])
        );
        assign w_fside[s] = r_fside[s];
    end

    // Setup of the divisions: numerator |d| * 2^F + r over 2r, with the
    // quotient too large for seventeen bits flagged up front.
    always_comb begin
        p_root = w_root[RTW];
        p_half = ({1'b0, p_root} + (RTW+1)'(1)) >> 1;
        p_d[0] = w_fside[RTW].d0;
        p_d[1] = w_fside[RTW].d1;
        p_d[2] = w_fside[RTW].d2;
        p_side.branch = w_fside[RTW].branch;
        p_side.rootq  = (p_half > (RTW+1)'(SAT_POS)) ? SAT_POS : 16'(p_half);
        for (int l = 0; l < 3; l++) begin
            p_mag[l] = p_d[l][16] ? 17'(-p_d[l]) : 17'(p_d[l]);
            p_num[l] = NNW'({p_mag[l], {FRAC_BITS{1'b0}}}) + NNW'(p_root);
            p_top[l] = DW'(p_num[l][NNW-1:QB]);
            p_side.neg[l] = p_d[l][16];
            p_side.ovf[l] = (p_top[l] >= {p_root, 1'b0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 1; s <= RTW; s++) begin
                r_fside[s] <= w_fside[s-1];
            end
            for (int l = 0; l < 3; l++) begin
                r_p_rem[l] <= p_side.ovf[l] ? '0 : p_top[l];
                r_p_low[l] <= p_num[l][QB-1:0];
            end
            r_dside[0] <= p_side;
            r_den[0]   <= {p_root, 1'b0};
            for (int s = 1; s <= QB; s++) begin
                r_dside[s] <= r_dside[s-1];
                r_den[s]   <= r_den[s-1];
            end
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign w_drem[l][0] = r_p_rem[l];
        assign w_dlow[l][0] = r_p_low[l];
        assign w_dq[l][0]   = '0;
        for (genvar s = 1; s <= QB; s++) begin : g_div
            rmq_div_cell #(.DW(DW)) u_cell (
                .i_clk(i_clk),
                .i_en (en),
                .i_rem(w_drem[l][s-1]),
                .i_den(r_den[s-1]),
                .i_low(w_dlow[l][s-1]),
                .i_q  (w_dq[l][s-1]),
                .o_rem(w_drem[l][s]),
                .o_low(w_dlow[l][s]),
                .o_q  (w_dq[l][s])
            );
        end
    end

    always_comb begin
        fin = r_dside[QB];
        for (int l = 0; l < 3; l++) begin
            lq = w_dq[l][QB];
            if (!fin.neg[l]) begin
                res_lane[l] = (fin.ovf[l] || lq > QB'(SAT_POS)) ? SAT_POS : lq[15:0];
            end else begin
                res_lane[l] = (fin.ovf[l] || lq > QB'(SAT_NEG)) ? SAT_NEG
                                                                : 16'(~lq + 1'b1);
            end
        end
        unique case (fin.branch)
            BR_TRACE: begin
                res_w = fin.rootq;   res_x = res_lane[0];
                res_y = res_lane[1]; res_z = res_lane[2];
            end
            BR_X: begin
                res_w = res_lane[0]; res_x = fin.rootq;
                res_y = res_lane[1]; res_z = res_lane[2];
            end
            BR_Y: begin
                res_w = res_lane[0]; res_x = res_lane[2];
                res_y = fin.rootq;   res_z = res_lane[1];
            end
            BR_Z: begin
                res_w = res_lane[0]; res_x = res_lane[1];
                res_y = res_lane[2]; res_z = fin.rootq;
            end
            default: begin
                res_w = '0; res_x = '0; res_y = '0; res_z = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= '0;
            r_ov  <= 1'b0;
            r_skv <= 1'b0;
        end else begin
            if (en) begin
                r_v <= {r_v[LAST-1:0], i_mat.valid};
            end
            if (o_quat.ready || !r_ov) begin
                r_ov  <= r_skv || incoming;
                r_skv <= 1'b0;
            end else if (incoming) begin
                r_skv <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_quat.ready || !r_ov) begin
            if (r_skv) begin
                r_ow <= r_sw; r_ox <= r_sx; r_oy <= r_sy; r_oz <= r_sz; r_ob <= r_sb;
            end else begin
                r_ow <= res_w; r_ox <= res_x; r_oy <= res_y; r_oz <= res_z;
                r_ob <= fin.branch;
            end
        end else if (incoming) begin
            r_sw <= res_w; r_sx <= res_x; r_sy <= res_y; r_sz <= res_z;
            r_sb <= fin.branch;
        end
    end

    assign o_quat.valid        = r_ov;
    assign o_quat.quat_w       = r_ow;
    assign o_quat.quat_x       = r_ox;
    assign o_quat.quat_y       = r_oy;
    assign o_quat.quat_z       = r_oz;
    assign o_quat.branch_taken = r_ob;

`ifndef ASSERT_OFF
    a_root_part_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> ((r_ob == BR_TRACE && r_ow != '0 && !r_ow[15]) ||
                  (r_ob == BR_X && r_ox != '0 && !r_ox[15]) ||
                  (r_ob == BR_Y && r_oy != '0 && !r_oy[15]) ||
                  (r_ob == BR_Z && r_oz != '0 && !r_oz[15])))
        else $error("root-derived component is not positive");
    a_skid_needs_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skv |-> r_ov)
        else $error("skid entry held without a pending output");
    a_accept_enters_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_mat.valid && i_mat.ready) |=> r_v[0])
        else $error("accepted transfer did not enter the pipeline");
`endif

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion core testbench
// Sends matrices over the input channel and checks every quaternion result
// against a bit-accurate predictor, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import rmq_pkg::*;

    localparam int FB      = 14;
    localparam int LAT     = 60;
    localparam int WD_MAX  = 5000;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        t_branch            br;
    } t_quat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   n_err = 0;
    int   idle_pct = 38;
    bit   hold_rx = 1'b0;
    bit   run_done = 1'b0;
    int   quiet_cycles = 0;
    t_quat quat_expected[$];

    rmq_mat_if  mat_ch();
    rmq_quat_if quat_ch();

    rotation_matrix_to_quaternion_core #(.FRAC_BITS(FB)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_mat  (mat_ch.sink),
        .o_quat (quat_ch.source)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        mat_ch.valid = 1'b0;
        {mat_ch.m00, mat_ch.m01, mat_ch.m02, mat_ch.m10, mat_ch.m11,
         mat_ch.m12, mat_ch.m20, mat_ch.m21, mat_ch.m22} = '0;
        quat_ch.ready = 1'b0;
    end

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > n) bt >>= 2;
        while (bt != 0) begin
            if (n >= res + bt) begin
                n -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned root_fx(longint rad);
        if (rad <= 0) rad = 1;
        return int_sqrt(longint'(unsigned'(rad)) << FB);
    endfunction

    function automatic longint pair_div(longint d, longint unsigned r);
        longint unsigned mag, qv;
        mag = (d < 0) ? longint'(-d) : d;
        qv = ((mag << FB) + r) / (2 * r);
        return (d < 0) ? -longint'(qv) : longint'(qv);
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767) return SAT_POS;
        if (v < -32768) return SAT_NEG;
        return v[15:0];
    endfunction

    function automatic t_quat quat_of(t_mat mt);
        longint m[3][3];
        longint q[4];
        longint one, tr;
        longint unsigned r;
        int i, j, k;
        t_quat res;
        one = 64'sd1 << FB;
        m[0][0] = mt.m00; m[0][1] = mt.m01; m[0][2] = mt.m02;
        m[1][0] = mt.m10; m[1][1] = mt.m11; m[1][2] = mt.m12;
        m[2][0] = mt.m20; m[2][1] = mt.m21; m[2][2] = mt.m22;
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0) begin
            r = root_fx(tr + one);
            q[0] = longint'((r + 1) >> 1);
            q[1] = pair_div(m[2][1] - m[1][2], r);
            q[2] = pair_div(m[0][2] - m[2][0], r);
            q[3] = pair_div(m[1][0] - m[0][1], r);
            res.br = BR_TRACE;
        end else begin
            i = 0;
            if (m[1][1] > m[0][0]) i = 1;
            if (m[2][2] > m[i][i]) i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            r = root_fx(m[i][i] - m[j][j] - m[k][k] + one);
            q[1 + i] = longint'((r + 1) >> 1);
            q[0] = pair_div(m[k][j] - m[j][k], r);
            q[1 + j] = pair_div(m[j][i] + m[i][j], r);
            q[1 + k] = pair_div(m[k][i] + m[i][k], r);
            res.br = (i == 0) ? BR_X : (i == 1) ? BR_Y : BR_Z;
        end
        res.w = clip16(q[0]);
        res.x = clip16(q[1]);
        res.y = clip16(q[2]);
        res.z = clip16(q[3]);
        return res;
    endfunction

    // Valid stays high after a transfer so that the next call can follow
    // back to back; wait_drained drops it when the sender pauses.
    task automatic send_matrix(t_mat mt);
        while ($urandom_range(99) < idle_pct) begin
            mat_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        mat_ch.valid <= 1'b1;
        {mat_ch.m00, mat_ch.m01, mat_ch.m02, mat_ch.m10, mat_ch.m11,
         mat_ch.m12, mat_ch.m20, mat_ch.m21, mat_ch.m22} <= mt;
        do @(posedge i_clk); while (!mat_ch.ready);
        quat_expected.push_back(quat_of(mt));
    endtask

    function automatic t_mat rand_mat();
        t_mat mt;
        mt = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
        return mt;
    endfunction

    // Near-rotation matrix: a random diagonal sign pattern plus noise.
    function automatic t_mat near_rot();
        t_mat mt;
        logic signed [15:0] e[9];
        int sel;
        sel = $urandom_range(3);
        foreach (e[n]) e[n] = $signed(16'($urandom_range(4000))) - 16'sd2000;
        if (sel == 0) begin
            e[0] += 16'sd12000; e[4] += 16'sd12000; e[8] += 16'sd12000;
        end else begin
            e[0] += (sel == 1) ? 16'sd16000 : -16'sd16000;
            e[4] += (sel == 2) ? 16'sd16000 : -16'sd16000;
            e[8] += (sel == 3) ? 16'sd16000 : -16'sd16000;
        end
        mt = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
        return mt;
    endfunction

    task automatic wait_drained();
        mat_ch.valid <= 1'b0;
        while (quat_expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        const logic signed [15:0] P1 = 16'sd16384;
        send_matrix({P1, 16'sd0, 16'sd0, 16'sd0, P1, 16'sd0, 16'sd0, 16'sd0, P1});
        send_matrix({P1, 16'sd0, 16'sd0, 16'sd0, -P1, 16'sd0, 16'sd0, 16'sd0, -P1});
        send_matrix({-P1, 16'sd0, 16'sd0, 16'sd0, P1, 16'sd0, 16'sd0, 16'sd0, -P1});
        send_matrix({-P1, 16'sd0, 16'sd0, 16'sd0, -P1, 16'sd0, 16'sd0, 16'sd0, P1});
        send_matrix('0);                           // all diagonals tie
        send_matrix({9{16'sh7FFF}});
        send_matrix({9{16'sh8000}});
        send_matrix({9{16'shFFFF}});
        send_matrix({16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
                     16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000}); // all diagonals at the minimum
        send_matrix({16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
                     16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000});
        send_matrix({16'sd100, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sd100,
                     16'sh7FFF, 16'sh7FFF, 16'sh8000, -16'sd199}); // tiny trace
        send_matrix({16'sd5, 16'sd0, 16'sd0, 16'sd0, 16'sd5, 16'sd0,
                     16'sd0, 16'sd0, -16'sd20});
        send_matrix({-16'sd5, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -16'sd5,
                     16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -16'sd5});
        send_matrix({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                     16'sd0, 16'sd0, 16'sd1});
        wait_drained();
    endtask

    task automatic test_random(int count);
        repeat (count) begin
            if ($urandom_range(99) < 70) send_matrix(near_rot());
            else send_matrix(rand_mat());
        end
    endtask

    task automatic test_no_idle(int count);
        idle_pct = 0;
        test_random(count);
        idle_pct = 38;
    endtask

    // The receiver holds off while the sender keeps offering, so the block
    // fills up and must stall its input.
    task automatic test_backpressure();
        hold_rx = 1'b1;
        fork
            begin
                repeat (200) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            test_no_idle(120);
        join
        wait_drained();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(600);
        test_backpressure();
        test_no_idle(250);
        test_random(550);
        wait_drained();
        repeat (LAT) @(posedge i_clk);
        run_done = 1'b1;
        if (n_err == 0) $display("tb_top: clean");
        else $display("tb_top: errors");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_rx) quat_ch.ready <= 1'b0;
        else quat_ch.ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        t_quat exp_q, got;
        if (i_rst_n && quat_ch.valid && quat_ch.ready) begin
            got = {quat_ch.quat_w, quat_ch.quat_x, quat_ch.quat_y, quat_ch.quat_z,
                   quat_ch.branch_taken};
            if (quat_expected.size() == 0) begin
                n_err++;
                $display("%0t: unexpected result %h", $time, got);
            end else begin
                exp_q = quat_expected.pop_front();
                if (got.w !== exp_q.w)
                    $display("%0t: quat_w expected %0d actual %0d", $time, exp_q.w, got.w);
                if (got.x !== exp_q.x)
                    $display("%0t: quat_x expected %0d actual %0d", $time, exp_q.x, got.x);
                if (got.y !== exp_q.y)
                    $display("%0t: quat_y expected %0d actual %0d", $time, exp_q.y, got.y);
                if (got.z !== exp_q.z)
                    $display("%0t: quat_z expected %0d actual %0d", $time, exp_q.z, got.z);
                if (got.br !== exp_q.br)
                    $display("%0t: branch_taken expected %0d actual %0d", $time,
                             exp_q.br, got.br);
                if (got !== exp_q) n_err++;
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge i_clk) begin
        if ((mat_ch.valid && mat_ch.ready) || (quat_ch.valid && quat_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WD_MAX && !run_done) begin
            $display("tb_top: errors");
            $finish;
        end
    end

endmodule
